[rtl/free_frame_area_allocator_core_defines.svh]
// Assertion macros used by the port-level checker of the frame area allocator.
// Depends on signals named clock and reset in the scope of each use.
`ifndef FREE_FRAME_AREA_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_FRAME_AREA_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ffa_pkg.sv]
// Shared types, sizes and codes of the free frame area allocator.
// No dependencies; every other file of the block but ffa_slot_ram and the defines header refers to it.
package ffa_pkg;

   localparam int AREA_SLOTS = 16;
   localparam int SLOT_IDX_W = (AREA_SLOTS > 1) ? $clog2(AREA_SLOTS) : 1;
   localparam int SCAN_CNT_W = $clog2(AREA_SLOTS + 1);

   localparam int OPCODE_W = 2;
   localparam int FRAME_W  = 20;
   localparam int MSIZE_W  = 22;
   localparam int ENTRY_W  = 2 * FRAME_W;

   localparam logic [FRAME_W-1:0] FIRST_FREE_FRAME = 20'h00800;

   localparam logic [OPCODE_W-1:0] OP_ALLOCATE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_INIT     = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               status;
      logic [FRAME_W-1:0] grant_start;
      logic [FRAME_W-1:0] grant_count;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } handoff_type;

endpackage

[rtl/free_frame_area_allocator_core.sv]
// Free frame area allocator: table of free physical-frame areas, scanned from slot zero.
//
// The req_ channel carries one transaction per operation: allocate (take
// frames from the first used slot), release (store an area in the first
// empty slot) or init (write slot zero). Every accepted transaction gives
// exactly one rsp_ transaction with status, grant_start and grant_count.
// The block works on one transaction at a time; req_ready is high while the
// sequencer is idle, even if the previous response still waits in the
// output register.
// An unknown opcode goes straight to the response, init writes slot zero first,
// and an allocate or release scans the slots until a hit, which is written back,
// or until the whole table is scanned without a hit. req_ready returns in the
// cycle after the response is handed to the output register. The slot scan
// reads one slot per cycle from the single read port of the slot RAM.
// A stalled receiver holds the response in the output register; the next
// transaction is accepted and processed, then waits until rsp_ready frees it.
// Synchronous reset marks all slots empty at once through per-slot valid
// bits; no clearing pass is needed and req_ready is high the cycle after.
module free_frame_area_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffa_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_request_count,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_area_begin,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_area_end,
   input  logic [ffa_pkg::MSIZE_W-1:0]   req_memory_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_start,
   output logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_count
);

   logic                           ram_wr_en;
   logic [ffa_pkg::SLOT_IDX_W-1:0] ram_wr_addr;
   logic [ffa_pkg::ENTRY_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [ffa_pkg::SLOT_IDX_W-1:0] ram_rd_addr;
   logic [ffa_pkg::ENTRY_W-1:0]    ram_rd_data;
   ffa_pkg::handoff_type           handoff;
   logic                           result_taken;

   logic                rsp_valid_ff, rsp_valid_in;
   ffa_pkg::result_type rsp_result_ff, rsp_result_in;

   ffa_slot_ram #(
      .DEPTH (ffa_pkg::AREA_SLOTS),
      .WIDTH (ffa_pkg::ENTRY_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_request_count (req_request_count),
      .req_area_begin    (req_area_begin),
      .req_area_end      (req_area_end),
      .req_memory_size   (req_memory_size),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .handoff           (handoff),
      .result_taken      (result_taken)
   );

   // The output register takes a finished result whenever it is empty or drains.
   assign result_taken  = handoff.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in  = result_taken || (rsp_valid_ff && !rsp_ready);
   assign rsp_result_in = result_taken ? handoff.result : rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_result_ff.status;
   assign rsp_grant_start = rsp_result_ff.grant_start;
   assign rsp_grant_count = rsp_result_ff.grant_count;

endmodule

[rtl/ffa_slot_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Holds the slot table of the allocator; no package dependency.
module ffa_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 40
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ffa_ctrl.sv]
// Sequencer of the allocator: scans the slot RAM, decides and writes back.
// Depends on ffa_pkg; drives the ports of ffa_slot_ram.
module ffa_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ffa_pkg::OPCODE_W-1:0]            req_opcode,
   input  logic [ffa_pkg::FRAME_W-1:0]             req_request_count,
   input  logic [ffa_pkg::FRAME_W-1:0]             req_area_begin,
   input  logic [ffa_pkg::FRAME_W-1:0]             req_area_end,
   input  logic [ffa_pkg::MSIZE_W-1:0]             req_memory_size,
   output logic                                    ram_wr_en,
   output logic [ffa_pkg::SLOT_IDX_W-1:0]          ram_wr_addr,
   output logic [ffa_pkg::ENTRY_W-1:0]             ram_wr_data,
   output logic                                    ram_rd_en,
   output logic [ffa_pkg::SLOT_IDX_W-1:0]          ram_rd_addr,
   input  logic [ffa_pkg::ENTRY_W-1:0]             ram_rd_data,
   output ffa_pkg::handoff_type                    handoff,
   input  logic                                    result_taken
);

   ffa_pkg::state_type                    state_ff, state_in;
   logic [ffa_pkg::SCAN_CNT_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                                  chk_vld_ff, chk_vld_in;
   logic [ffa_pkg::SLOT_IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   logic [ffa_pkg::AREA_SLOTS-1:0]        valid_ff, valid_in;
   logic [ffa_pkg::OPCODE_W-1:0]          op_ff, op_in;
   logic [ffa_pkg::FRAME_W-1:0]           want_ff, want_in;
   logic [ffa_pkg::SLOT_IDX_W-1:0]        wr_idx_ff, wr_idx_in;
   logic [ffa_pkg::ENTRY_W-1:0]           wr_data_ff, wr_data_in;
   ffa_pkg::result_type                   result_ff, result_in;

   logic [ffa_pkg::FRAME_W-1:0] cur_begin;
   logic [ffa_pkg::FRAME_W-1:0] cur_end;
   logic [ffa_pkg::FRAME_W-1:0] cur_size;
   logic [ffa_pkg::FRAME_W-1:0] cut_begin;
   logic                        cur_used;
   logic                        cur_larger;
   logic                        is_alloc;
   logic                        chk_hit;
   logic                        chk_last;
   logic                        scan_issue;

   // An entry that was never written reads as an empty slot.
   assign cur_begin  = valid_ff[chk_idx_ff] ? ram_rd_data[ffa_pkg::ENTRY_W-1:ffa_pkg::FRAME_W]
                                            : '0;
   assign cur_end    = valid_ff[chk_idx_ff] ? ram_rd_data[ffa_pkg::FRAME_W-1:0] : '0;
   assign cur_size   = (cur_end >= cur_begin) ? (cur_end - cur_begin) : '0;
   assign cut_begin  = cur_begin + want_ff;
   assign cur_used   = (cur_begin != '0);
   assign cur_larger = (cur_size > want_ff);
   assign is_alloc   = (op_ff == ffa_pkg::OP_ALLOCATE);
   assign chk_hit    = chk_vld_ff && (is_alloc ? cur_used : !cur_used);
   assign chk_last   = chk_vld_ff &&
                       (chk_idx_ff == ffa_pkg::SLOT_IDX_W'(ffa_pkg::AREA_SLOTS - 1));
   assign scan_issue = (state_ff == ffa_pkg::ST_SCAN) &&
                       (scan_cnt_ff < ffa_pkg::SCAN_CNT_W'(ffa_pkg::AREA_SLOTS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  ffa_pkg::OP_ALLOCATE: state_in = ffa_pkg::ST_SCAN;
                  ffa_pkg::OP_RELEASE:  state_in = ffa_pkg::ST_SCAN;
                  ffa_pkg::OP_INIT:     state_in = ffa_pkg::ST_WRITE;
                  default:              state_in = ffa_pkg::ST_DONE;
               endcase
            end
         end
         ffa_pkg::ST_SCAN: begin
            if (chk_hit) begin
               state_in = ffa_pkg::ST_WRITE;
            end else if (chk_last) begin
               state_in = ffa_pkg::ST_DONE;
            end
         end
         ffa_pkg::ST_WRITE: begin
            state_in = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_DONE: begin
            if (result_taken) begin
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_ready      = (state_ff == ffa_pkg::ST_IDLE);
      ram_rd_en      = scan_issue;
      ram_rd_addr    = scan_cnt_ff[ffa_pkg::SLOT_IDX_W-1:0];
      ram_wr_en      = (state_ff == ffa_pkg::ST_WRITE);
      ram_wr_addr    = wr_idx_ff;
      ram_wr_data    = wr_data_ff;
      handoff.valid  = (state_ff == ffa_pkg::ST_DONE);
      handoff.result = result_ff;

      scan_cnt_in = scan_issue ? (scan_cnt_ff + 1'b1) : scan_cnt_ff;
      chk_vld_in  = scan_issue;
      chk_idx_in  = scan_cnt_ff[ffa_pkg::SLOT_IDX_W-1:0];
      valid_in    = valid_ff;
      op_in       = op_ff;
      want_in     = want_ff;
      wr_idx_in   = wr_idx_ff;
      wr_data_in  = wr_data_ff;
      result_in   = result_ff;

      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_opcode;
               want_in     = req_request_count;
               scan_cnt_in = '0;
               result_in   = '0;
               wr_idx_in   = '0;
               if (req_opcode == ffa_pkg::OP_INIT) begin
                  wr_data_in = {ffa_pkg::FIRST_FREE_FRAME,
                                req_memory_size[ffa_pkg::MSIZE_W-1:2]};
               end else begin
                  wr_data_in = {req_area_begin, req_area_end};
               end
            end
         end
         ffa_pkg::ST_SCAN: begin
            if (chk_hit) begin
               wr_idx_in = chk_idx_ff;
               if (is_alloc) begin
                  result_in.status      = ffa_pkg::STATUS_DONE;
                  result_in.grant_start = cur_begin;
                  result_in.grant_count = cur_larger ? want_ff : cur_size;
                  wr_data_in = {(cur_larger ? cut_begin : {ffa_pkg::FRAME_W{1'b0}}), cur_end};
               end
            end else if (chk_last && is_alloc) begin
               result_in.status      = ffa_pkg::STATUS_FAIL;
               result_in.grant_start = '0;
               result_in.grant_count = '0;
            end
         end
         ffa_pkg::ST_WRITE: begin
            valid_in[wr_idx_ff] = 1'b1;
         end
         ffa_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ffa_pkg::ST_IDLE;
         scan_cnt_ff <= '0;
         chk_vld_ff  <= 1'b0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         chk_vld_ff  <= chk_vld_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      op_ff      <= op_in;
      want_ff    <= want_in;
      wr_idx_ff  <= wr_idx_in;
      wr_data_ff <= wr_data_in;
      result_ff  <= result_in;
   end

endmodule

[rtl/ffa_checker.sv]
// Port-level checker for the frame area allocator, bound to the top level.
// Depends on ffa_pkg and the assertion macros of the defines header.
`include "free_frame_area_allocator_core_defines.svh"

module ffa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [ffa_pkg::OPCODE_W-1:0]  req_opcode,
   input logic [ffa_pkg::FRAME_W-1:0]   req_request_count,
   input logic [ffa_pkg::FRAME_W-1:0]   req_area_begin,
   input logic [ffa_pkg::FRAME_W-1:0]   req_area_end,
   input logic [ffa_pkg::MSIZE_W-1:0]   req_memory_size,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_start,
   input logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_count
);

   logic [ffa_pkg::OPCODE_W+3*ffa_pkg::FRAME_W+ffa_pkg::MSIZE_W-1:0] req_payload;

   assign req_payload = {req_opcode, req_request_count, req_area_begin, req_area_end,
                         req_memory_size};

   // A waiting request must hold until it is accepted.
   `FFA_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_payload), "waiting request changed")

   // A stalled response must hold.
   `FFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_grant_start) && $stable(rsp_grant_count), "stalled response changed")

   // Only one transaction is processed at a time.
   `FFA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request accepted while busy")

   // A failed allocate grants nothing.
   `FFA_ASSERT_SAME(a_fail_empty, rsp_valid && (rsp_status == ffa_pkg::STATUS_FAIL), (rsp_grant_start == '0) && (rsp_grant_count == '0), "failed allocate with nonzero grant")

endmodule

bind free_frame_area_allocator_core ffa_checker u_ffa_checker (.*);

[tb/sv/free_frame_area_allocator_core_checker.sv]
`timescale 1ns / 1ps
// Response checker for the free frame area allocator: keeps its own slot table,
// predicts the response of each req_ transaction and compares it with rsp_.
// Depends on ffa_pkg for widths, opcodes, status codes and the result struct.
module free_frame_area_allocator_core_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [ffa_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_request_count,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_area_begin,
   input  logic [ffa_pkg::FRAME_W-1:0]   req_area_end,
   input  logic [ffa_pkg::MSIZE_W-1:0]   req_memory_size,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_status,
   input  logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_start,
   input  logic [ffa_pkg::FRAME_W-1:0]   rsp_grant_count,
   output int                            mismatch_count,
   output int                            outstanding
);
   import ffa_pkg::*;

   logic [FRAME_W-1:0] area_first [AREA_SLOTS];
   logic [FRAME_W-1:0] area_last  [AREA_SLOTS];
   result_type         expected_grants [$];

   // Applies one operation to the slot table and returns the response it yields.
   function automatic result_type predict_grant(
      input logic [OPCODE_W-1:0] op,
      input logic [FRAME_W-1:0]  want,
      input logic [FRAME_W-1:0]  first,
      input logic [FRAME_W-1:0]  last,
      input logic [MSIZE_W-1:0]  msize
   );
      result_type         r;
      logic [FRAME_W-1:0] span;
      logic               hit;
      r = '0;
      r.status = STATUS_DONE;
      hit = 1'b0;
      case (op)
         OP_ALLOCATE: begin
            r.status = STATUS_FAIL;
            for (int i = 0; i < AREA_SLOTS; i++) begin
               if (!hit && area_first[i] != '0) begin
                  hit = 1'b1;
                  span = (area_last[i] >= area_first[i]) ? area_last[i] - area_first[i] : '0;
                  r.status = STATUS_DONE;
                  r.grant_start = area_first[i];
                  if (area_last[i] > area_first[i] && span > want) begin
                     area_first[i] = area_first[i] + want;
                     r.grant_count = want;
                  end else begin
                     // The whole area goes out, including a reversed one with no frames.
                     area_first[i] = '0;
                     r.grant_count = span;
                  end
               end
            end
         end
         OP_RELEASE: begin
            // A full table drops the area without any indication.
            for (int i = 0; i < AREA_SLOTS; i++) begin
               if (!hit && area_first[i] == '0) begin
                  hit = 1'b1;
                  area_first[i] = first;
                  area_last[i] = last;
               end
            end
         end
         OP_INIT: begin
            area_first[0] = FIRST_FREE_FRAME;
            area_last[0] = msize[MSIZE_W-1:2];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want_r;
      if (reset) begin
         for (int i = 0; i < AREA_SLOTS; i++) begin
            area_first[i] = '0;
            area_last[i] = '0;
         end
         expected_grants.delete();
      end else begin
         // Responses are handled first: one accepted on this edge belongs to an
         // older transaction than any request accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $display("%0t: unexpected response status %0d start %h count %h", $time,
                        rsp_status, rsp_grant_start, rsp_grant_count);
               mismatch_count++;
            end else begin
               want_r = expected_grants.pop_front();
               if (rsp_status !== want_r.status) begin
                  $display("%0t: status expected %0d, actual %0d", $time,
                           want_r.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_grant_start !== want_r.grant_start) begin
                  $display("%0t: grant_start expected %h, actual %h", $time,
                           want_r.grant_start, rsp_grant_start);
                  mismatch_count++;
               end
               if (rsp_grant_count !== want_r.grant_count) begin
                  $display("%0t: grant_count expected %h, actual %h", $time,
                           want_r.grant_count, rsp_grant_count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_grants.push_back(predict_grant(req_opcode, req_request_count,
                                                    req_area_begin, req_area_end,
                                                    req_memory_size));
         end
      end
      outstanding <= expected_grants.size();
   end

endmodule

[tb/sv/free_frame_area_allocator_core_tb.sv]
`timescale 1ns / 1ps
// Top of the free frame area allocator testbench: clock, reset, stimulus and verdict.
// Depends on ffa_pkg, the allocator core and free_frame_area_allocator_core_checker.
module free_frame_area_allocator_core_tb;
   import ffa_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES = 30;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode;
   logic [FRAME_W-1:0]  req_request_count;
   logic [FRAME_W-1:0]  req_area_begin;
   logic [FRAME_W-1:0]  req_area_end;
   logic [MSIZE_W-1:0]  req_memory_size;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_status;
   logic [FRAME_W-1:0]  rsp_grant_start;
   logic [FRAME_W-1:0]  rsp_grant_count;
   int                  mismatch_count;
   int                  outstanding;
   logic                idle_enable;
   logic                hold_off_request;

   free_frame_area_allocator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_request_count (req_request_count),
      .req_area_begin    (req_area_begin),
      .req_area_end      (req_area_end),
      .req_memory_size   (req_memory_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_grant_start   (rsp_grant_start),
      .rsp_grant_count   (rsp_grant_count)
   );

   free_frame_area_allocator_core_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_request_count (req_request_count),
      .req_area_begin    (req_area_begin),
      .req_area_end      (req_area_end),
      .req_memory_size   (req_memory_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_grant_start   (rsp_grant_start),
      .rsp_grant_count   (rsp_grant_count),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one transaction and returns on the edge where it is accepted.
   task automatic send_op(
      input logic [OPCODE_W-1:0] op,
      input logic [FRAME_W-1:0]  want,
      input logic [FRAME_W-1:0]  first,
      input logic [FRAME_W-1:0]  last,
      input logic [MSIZE_W-1:0]  msize
   );
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_request_count <= want;
      req_area_begin <= first;
      req_area_end <= last;
      req_memory_size <= msize;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly small areas and requests near their sizes so that slots get cut,
   // emptied and refilled; the rest spans the full field ranges.
   task automatic send_random(input int release_pct);
      int                 roll;
      int                 shape;
      logic [OPCODE_W-1:0] op;
      logic [FRAME_W-1:0] want;
      logic [FRAME_W-1:0] first;
      logic [FRAME_W-1:0] last;
      logic [MSIZE_W-1:0] msize;
      roll = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      want = FRAME_W'($urandom_range(0, 20'hFFFFF));
      first = FRAME_W'($urandom_range(0, 20'hFFFFF));
      last = FRAME_W'($urandom_range(0, 20'hFFFFF));
      msize = MSIZE_W'($urandom_range(0, 22'h3FFFFF));
      if (roll < 3) begin
         op = OP_UNUSED;
      end else if (roll < 8) begin
         op = OP_INIT;
         if (shape < 20) msize = MSIZE_W'($urandom_range(0, 22'h2100));
      end else if (roll < 8 + release_pct) begin
         op = OP_RELEASE;
         if (shape < 85) begin
            first = FRAME_W'($urandom_range(1, 20'hFFFBF));
            last = first + FRAME_W'($urandom_range(0, 64));
         end else if (shape < 90) begin
            first = '0;
         end
      end else begin
         op = OP_ALLOCATE;
         if (shape < 80) want = FRAME_W'($urandom_range(0, 70));
      end
      send_op(op, want, first, last, msize);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Receiver: random short stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("free_frame_area_allocator_core test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ALLOCATE;
      req_request_count = '0;
      req_area_begin = '0;
      req_area_end = '0;
      req_memory_size = '0;
      idle_enable = 1'b0;
      hold_off_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table, unknown opcode, and a full-size init cut and then taken whole.
      send_op(OP_ALLOCATE, 20'd5, '0, '0, '0);
      send_op(OP_UNUSED, '1, '1, '1, '1);
      send_op(OP_INIT, '0, '0, '0, 22'h3FFFFF);
      send_op(OP_ALLOCATE, 20'd0, '0, '0, '0);
      send_op(OP_ALLOCATE, 20'hFFFFF, '0, '0, '0);
      send_op(OP_ALLOCATE, 20'd1, '0, '0, '0);
      // Init with a zero size leaves an area whose end lies below its begin.
      send_op(OP_INIT, '0, '0, '0, '0);
      send_op(OP_ALLOCATE, 20'd5, '0, '0, '0);
      // An area released with a zero begin stays empty.
      send_op(OP_RELEASE, '0, '0, 20'h00123, '0);
      send_op(OP_ALLOCATE, 20'd1, '0, '0, '0);
      send_op(OP_RELEASE, '0, 20'hFFFFF, 20'hFFFFF, '0);
      send_op(OP_ALLOCATE, 20'd0, '0, '0, '0);
      // Exact fit, one frame short, and the single frame left over.
      send_op(OP_RELEASE, '0, 20'd100, 20'd200, '0);
      send_op(OP_ALLOCATE, 20'd100, '0, '0, '0);
      send_op(OP_RELEASE, '0, 20'd100, 20'd200, '0);
      send_op(OP_ALLOCATE, 20'd99, '0, '0, '0);
      send_op(OP_ALLOCATE, 20'd5, '0, '0, '0);
      send_op(OP_RELEASE, '0, 20'h00001, 20'hFFFFF, '0);
      send_op(OP_ALLOCATE, 20'hFFFFE, '0, '0, '0);
      send_op(OP_INIT, '0, '0, '0, 22'h3FFFFF);
      send_op(OP_RELEASE, '0, 20'hABCDE, 20'h54321, '0);
      send_op(OP_ALLOCATE, 20'hFFFFF, '0, '0, '0);
      send_op(OP_ALLOCATE, 20'd3, '0, '0, '0);
      send_op(OP_UNUSED, '0, '0, '0, '0);

      idle_enable = 1'b1;
      repeat (200) send_random(40);

      // The receiver stalls while transactions keep coming, so the core backs up.
      hold_off_request = 1'b1;
      repeat (8) send_random(40);

      // Release-heavy stretch fills the table and overflows it.
      repeat (150) send_random(70);

      req_valid <= 1'b0;
      wait_drained();

      repeat (150) send_random(20);

      idle_enable = 1'b0;
      repeat (150) send_random(40);

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("free_frame_area_allocator_core test passed");
      end else begin
         $display("free_frame_area_allocator_core test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_slot_ram.sv
rtl/ffa_ctrl.sv
rtl/free_frame_area_allocator_core.sv
rtl/ffa_checker.sv
tb/sv/free_frame_area_allocator_core_checker.sv
tb/sv/free_frame_area_allocator_core_tb.sv
